@@ sv/tpbm_pkg.sv @@
// ----------------------------------------------------------------------------
// True-peak ballistic meter package
// Word types, register and command codes, and fixed-point constants shared
// by the meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpbm_pkg;

   localparam int SAMPLE_W = 28;
   localparam int COEF_W   = 24;
   localparam int PEAK_W   = 29;
   localparam int PROD_W   = PEAK_W + COEF_W;
   localparam int CSR_IDX_W = 3;
   localparam int OVERSAMPLE = 4;

   localparam logic [1:0] KIND_SAMPLES = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_FAST_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_ATTACK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_FACTOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK_ONLY    = 3'd4;

   localparam logic [COEF_W-1:0] FAST_ATTACK_RST  = 24'd349525;
   localparam logic [COEF_W-1:0] SLOW_ATTACK_RST  = 24'd1502968;
   localparam logic [COEF_W-1:0] DECAY_FACTOR_RST = 24'd16776604;
   localparam logic [COEF_W-1:0] OUTPUT_GAIN_RST  = 24'd8422163;

   localparam logic [SAMPLE_W-1:0] LEVEL_LIMIT = 28'd167772160;
   localparam logic [SAMPLE_W-1:0] MAG_MAX     = 28'd134217728;

   typedef struct packed {
      logic [1:0]                 kind;
      logic signed [SAMPLE_W-1:0] sample_0;
      logic signed [SAMPLE_W-1:0] sample_1;
      logic signed [SAMPLE_W-1:0] sample_2;
      logic signed [SAMPLE_W-1:0] sample_3;
   } req_type;

   typedef struct packed {
      logic [PEAK_W-1:0]   ballistic_peak;
      logic [SAMPLE_W-1:0] sample_peak;
   } rsp_type;

   function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] raw);
      magnitude = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
   endfunction

endpackage

@@ sv/true_peak_ballistic_meter.sv @@
// ----------------------------------------------------------------------------
// True-peak ballistic meter
// A sample word holds req_ready low in ballistic mode while one shared 29x24
// multiplier runs decay then eight attack steps, and in peak-only mode while the
// S_PEAK steps scan its samples. A read word passes S_RD_MUL and S_RD_PUT and
// delivers its result once the output register is free; a clear acts on acceptance.
// Synchronous active-high reset loads the register defaults, zeroes the levels
// and peaks, and leaves a restart pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module true_peak_ballistic_meter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tpbm_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tpbm_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_en,
   input  logic [tpbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tpbm_pkg::COEF_W-1:0]        csr_wdata
);
   import tpbm_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RUN    = 3'd1;
   localparam logic [2:0] S_PEAK   = 3'd2;
   localparam logic [2:0] S_RD_MUL = 3'd3;
   localparam logic [2:0] S_RD_PUT = 3'd4;

   localparam logic [3:0] RUN_LAST  = 4'd11;
   localparam logic [3:0] PEAK_LAST = 4'(OVERSAMPLE - 1);

   logic [2:0]          state_ff, state_in;
   logic [3:0]          step_ff, step_in;
   logic                restart_ff, restart_in;
   logic [SAMPLE_W-1:0] fast_level_ff, fast_level_in;
   logic [SAMPLE_W-1:0] slow_level_ff, slow_level_in;
   logic [PEAK_W-1:0]   level_max_ff, level_max_in;
   logic [SAMPLE_W-1:0] sample_max_ff, sample_max_in;
   logic [SAMPLE_W-1:0] mag_ff [OVERSAMPLE];
   logic [SAMPLE_W-1:0] mag_in [OVERSAMPLE];
   logic [SAMPLE_W-1:0] slow_mag_ff, slow_mag_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [COEF_W-1:0]   fast_attack_ff, fast_attack_in;
   logic [COEF_W-1:0]   slow_attack_ff, slow_attack_in;
   logic [COEF_W-1:0]   decay_factor_ff, decay_factor_in;
   logic [COEF_W-1:0]   output_gain_ff, output_gain_in;
   logic                peak_only_ff, peak_only_in;

   logic                req_fire;
   logic [PEAK_W-1:0]   mul_a;
   logic [COEF_W-1:0]   mul_b;
   logic [SAMPLE_W-1:0] prod_lvl;
   logic [PEAK_W-1:0]   prod_peak;
   logic [PEAK_W-1:0]   level_sum;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign prod_lvl  = prod_ff[COEF_W +: SAMPLE_W];
   assign prod_peak = prod_ff[COEF_W +: PEAK_W];
   assign level_sum = {1'b0, fast_level_ff} + {1'b0, slow_level_ff};

   // Shared multiplier: even steps serve the fast level, odd steps the slow one.
   always_comb begin
      mul_a = level_max_ff;
      mul_b = output_gain_ff;
      if (state_ff == S_RUN) begin
         if (!step_ff[0]) begin
            if (step_ff == 4'd0) begin
               mul_a = {1'b0, fast_level_ff};
               mul_b = decay_factor_ff;
            end else begin
               mul_a = {1'b0, mag_ff[0] - fast_level_ff};
               mul_b = fast_attack_ff;
            end
         end else begin
            if (step_ff == 4'd1) begin
               mul_a = {1'b0, slow_level_ff};
               mul_b = decay_factor_ff;
            end else begin
               mul_a = {1'b0, mag_ff[0] - slow_level_ff};
               mul_b = slow_attack_ff;
            end
         end
      end
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      fast_attack_in  = fast_attack_ff;
      slow_attack_in  = slow_attack_ff;
      decay_factor_in = decay_factor_ff;
      output_gain_in  = output_gain_ff;
      peak_only_in    = peak_only_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_FAST_ATTACK:  fast_attack_in  = csr_wdata;
            REG_SLOW_ATTACK:  slow_attack_in  = csr_wdata;
            REG_DECAY_FACTOR: decay_factor_in = csr_wdata;
            REG_OUTPUT_GAIN:  output_gain_in  = csr_wdata;
            REG_PEAK_ONLY:    peak_only_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      restart_in    = restart_ff;
      fast_level_in = fast_level_ff;
      slow_level_in = slow_level_ff;
      level_max_in  = level_max_ff;
      sample_max_in = sample_max_ff;
      mag_in        = mag_ff;
      slow_mag_in   = slow_mag_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_data.kind)
                  KIND_SAMPLES: begin
                     mag_in[0] = magnitude(req_data.sample_0);
                     mag_in[1] = magnitude(req_data.sample_1);
                     mag_in[2] = magnitude(req_data.sample_2);
                     mag_in[3] = magnitude(req_data.sample_3);
                     if (restart_ff) begin
                        level_max_in  = '0;
                        sample_max_in = '0;
                        restart_in    = 1'b0;
                     end
                     step_in  = '0;
                     state_in = peak_only_ff ? S_PEAK : S_RUN;
                  end
                  KIND_READ: begin
                     restart_in = 1'b1;
                     state_in   = S_RD_MUL;
                  end
                  KIND_CLEAR: begin
                     level_max_in  = '0;
                     sample_max_in = '0;
                     restart_in    = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_RUN: begin
            step_in = step_ff + 4'd1;
            if (step_ff == RUN_LAST) begin
               if (level_sum > level_max_ff) begin
                  level_max_in = level_sum;
               end
               if (fast_level_ff > LEVEL_LIMIT) begin
                  fast_level_in = LEVEL_LIMIT;
               end
               if (slow_level_ff > LEVEL_LIMIT) begin
                  slow_level_in = LEVEL_LIMIT;
               end
               state_in = S_IDLE;
            end else if (step_ff[0]) begin
               if (step_ff == 4'd1) begin
                  fast_level_in = prod_lvl;
               end else begin
                  if (mag_ff[0] > fast_level_ff) begin
                     fast_level_in = fast_level_ff + prod_lvl;
                  end
                  slow_mag_in = mag_ff[0];
                  for (int i = 0; i < OVERSAMPLE; i++) begin
                     mag_in[i] = mag_ff[(i + 1) % OVERSAMPLE];
                  end
               end
            end else if (step_ff == 4'd2) begin
               slow_level_in = prod_lvl;
            end else if (step_ff != 4'd0) begin
               if (slow_mag_ff > slow_level_ff) begin
                  slow_level_in = slow_level_ff + prod_lvl;
               end
               if (slow_mag_ff > sample_max_ff) begin
                  sample_max_in = slow_mag_ff;
               end
            end
         end
         S_PEAK: begin
            if ({1'b0, mag_ff[0]} > level_max_ff) begin
               level_max_in = {1'b0, mag_ff[0]};
            end
            if (mag_ff[0] > sample_max_ff) begin
               sample_max_in = mag_ff[0];
            end
            for (int i = 0; i < OVERSAMPLE; i++) begin
               mag_in[i] = mag_ff[(i + 1) % OVERSAMPLE];
            end
            step_in = step_ff + 4'd1;
            if (step_ff == PEAK_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_RD_MUL: begin
            state_in = S_RD_PUT;
         end
         S_RD_PUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.ballistic_peak = peak_only_ff ? level_max_ff : prod_peak;
               rsp_data_in.sample_peak    = sample_max_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         step_ff         <= '0;
         restart_ff      <= 1'b1;
         fast_level_ff   <= '0;
         slow_level_ff   <= '0;
         level_max_ff    <= '0;
         sample_max_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         fast_attack_ff  <= FAST_ATTACK_RST;
         slow_attack_ff  <= SLOW_ATTACK_RST;
         decay_factor_ff <= DECAY_FACTOR_RST;
         output_gain_ff  <= OUTPUT_GAIN_RST;
         peak_only_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         restart_ff      <= restart_in;
         fast_level_ff   <= fast_level_in;
         slow_level_ff   <= slow_level_in;
         level_max_ff    <= level_max_in;
         sample_max_ff   <= sample_max_in;
         rsp_valid_ff    <= rsp_valid_in;
         fast_attack_ff  <= fast_attack_in;
         slow_attack_ff  <= slow_attack_in;
         decay_factor_ff <= decay_factor_in;
         output_gain_ff  <= output_gain_in;
         peak_only_ff    <= peak_only_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      slow_mag_ff <= slow_mag_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (fast_level_ff <= LEVEL_LIMIT))
      else $error("Fast level above its limit while idle.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (slow_level_ff <= LEVEL_LIMIT))
      else $error("Slow level above its limit while idle.");

   assert property (@(posedge clock) disable iff (reset)
      sample_max_ff <= MAG_MAX)
      else $error("Sample peak exceeds the largest magnitude.");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.kind == KIND_READ) && !rsp_valid_ff) |-> ##3 rsp_valid_ff)
      else $error("Read word did not deliver its result.");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// True-peak ballistic meter testbench
// Drives sample, read, clear and unused words into the meter under several
// register settings and idle patterns. A cycle-free model of the meter
// predicts the peak reports, or a directed row gives one outright, and each
// report the meter returns is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import tpbm_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [COEF_W-1:0]   COEF_ALL_ONES   = {COEF_W{1'b1}};
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int MAX_SEND_GAP    = 60;

   typedef struct {
      req_type word;
      bit      peak_only;
      bit      typed;
      rsp_type report;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0]    csr_wdata = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_off_req   = 1'b0;
   int mismatches     = 0;
   int quiet_cycles   = 0;

   rsp_type peak_reports_q[$];

   // Meter model state and register copies.
   logic [COEF_W-1:0]   m_fast_att   = FAST_ATTACK_RST;
   logic [COEF_W-1:0]   m_slow_att   = SLOW_ATTACK_RST;
   logic [COEF_W-1:0]   m_decay      = DECAY_FACTOR_RST;
   logic [COEF_W-1:0]   m_gain       = OUTPUT_GAIN_RST;
   bit                  m_peak_only  = 1'b0;
   logic [SAMPLE_W-1:0] m_fast       = '0;
   logic [SAMPLE_W-1:0] m_slow       = '0;
   logic [PEAK_W-1:0]   m_level_max  = '0;
   logic [SAMPLE_W-1:0] m_sample_max = '0;
   bit                  m_restart    = 1'b1;

   true_peak_ballistic_meter dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [SAMPLE_W-1:0] abs_value(input logic [SAMPLE_W-1:0] raw);
      return raw[SAMPLE_W-1] ? (SAMPLE_W'(0) - raw) : raw;
   endfunction

   function automatic logic [PEAK_W-1:0] coef_product(input logic [PEAK_W-1:0] x,
                                                      input logic [COEF_W-1:0] c);
      logic [PROD_W-1:0] p;
      p = PROD_W'(x) * PROD_W'(c);
      return p[PROD_W-1:COEF_W];
   endfunction

   function automatic logic [SAMPLE_W-1:0] attack_step(input logic [SAMPLE_W-1:0] level,
                                                       input logic [SAMPLE_W-1:0] v,
                                                       input logic [COEF_W-1:0] frac);
      if (v > level)
         level = level + SAMPLE_W'(coef_product(PEAK_W'(v - level), frac));
      return level;
   endfunction

   function automatic bit predict_peak_report(input req_type w, output rsp_type report);
      logic [SAMPLE_W-1:0] mags [OVERSAMPLE];
      logic [PEAK_W-1:0]   level_sum;
      report = '0;
      mags[0] = abs_value(w.sample_0);
      mags[1] = abs_value(w.sample_1);
      mags[2] = abs_value(w.sample_2);
      mags[3] = abs_value(w.sample_3);
      case (w.kind)
         KIND_SAMPLES: begin
            if (m_restart) begin
               m_level_max  = '0;
               m_sample_max = '0;
               m_restart    = 1'b0;
            end
            if (m_peak_only) begin
               for (int i = 0; i < OVERSAMPLE; i++) begin
                  if (PEAK_W'(mags[i]) > m_level_max) m_level_max = PEAK_W'(mags[i]);
                  if (mags[i] > m_sample_max) m_sample_max = mags[i];
               end
            end else begin
               m_fast = SAMPLE_W'(coef_product(PEAK_W'(m_fast), m_decay));
               m_slow = SAMPLE_W'(coef_product(PEAK_W'(m_slow), m_decay));
               for (int i = 0; i < OVERSAMPLE; i++) begin
                  m_fast = attack_step(m_fast, mags[i], m_fast_att);
                  m_slow = attack_step(m_slow, mags[i], m_slow_att);
                  if (mags[i] > m_sample_max) m_sample_max = mags[i];
               end
               level_sum = PEAK_W'(m_fast) + PEAK_W'(m_slow);
               if (level_sum > m_level_max) m_level_max = level_sum;
               if (m_fast > LEVEL_LIMIT) m_fast = LEVEL_LIMIT;
               if (m_slow > LEVEL_LIMIT) m_slow = LEVEL_LIMIT;
            end
            return 1'b0;
         end
         KIND_READ: begin
            report.ballistic_peak = m_peak_only ? m_level_max
                                                : coef_product(m_level_max, m_gain);
            report.sample_peak = m_sample_max;
            m_restart = 1'b1;
            return 1'b1;
         end
         KIND_CLEAR: begin
            m_level_max  = '0;
            m_sample_max = '0;
            m_restart    = 1'b1;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MOST_NEG;
         1:       return SAMPLE_MOST_POS;
         2:       return '0;
         3, 4:    return SAMPLE_W'($urandom_range(2047)) - SAMPLE_W'(1024);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic req_type random_word(input int read_pct);
      req_type w;
      int pick;
      pick = $urandom_range(99);
      if (pick < read_pct)
         w.kind = KIND_READ;
      else if (pick < read_pct + 5)
         w.kind = KIND_CLEAR;
      else if (pick < read_pct + 9)
         w.kind = KIND_UNUSED;
      else
         w.kind = KIND_SAMPLES;
      w.sample_0 = random_sample();
      w.sample_1 = random_sample();
      w.sample_2 = random_sample();
      w.sample_3 = random_sample();
      return w;
   endfunction

   function automatic dir_row_type make_row(input logic [1:0] kind,
                                            input logic [SAMPLE_W-1:0] s0, s1, s2, s3,
                                            input bit po, input bit typed,
                                            input logic [PEAK_W-1:0] bp,
                                            input logic [SAMPLE_W-1:0] sp);
      dir_row_type r;
      r.word      = '{kind, s0, s1, s2, s3};
      r.peak_only = po;
      r.typed     = typed;
      r.report    = '{bp, sp};
      return r;
   endfunction

   task automatic send_word(input req_type w, input bit typed, input rsp_type typed_rsp);
      int      gap;
      bit      has_rsp;
      rsp_type predicted;
      gap = 0;
      while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      has_rsp = predict_peak_report(w, predicted);
      if (has_rsp) peak_reports_q.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (peak_reports_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         REG_FAST_ATTACK:  m_fast_att  = val;
         REG_SLOW_ATTACK:  m_slow_att  = val;
         REG_DECAY_FACTOR: m_decay     = val;
         REG_OUTPUT_GAIN:  m_gain      = val;
         REG_PEAK_ONLY:    m_peak_only = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [COEF_W-1:0] fa, sa, dec, gain, input bit po,
                            input int send_pct, recv_pct, words, input bit pressure);
      settle_block();
      write_reg(REG_FAST_ATTACK, fa);
      write_reg(REG_SLOW_ATTACK, sa);
      write_reg(REG_DECAY_FACTOR, dec);
      write_reg(REG_OUTPUT_GAIN, gain);
      write_reg(REG_PEAK_ONLY, COEF_W'(po));
      write_reg(CSR_IDX_W'($urandom_range(int'(REG_PEAK_ONLY) + 1, (1 << CSR_IDX_W) - 1)),
                COEF_W'($urandom()));
      csr_write_en   <= 1'b0;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (pressure) hold_off_req = 1'b1;
      repeat (words) send_word(random_word(pressure ? 60 : 16), 1'b0, '0);
   endtask

   always @(negedge clock) begin
      if (hold_off_req) begin
         rsp_ready <= 1'b0;
         repeat (HOLD_OFF_CYCLES) @(negedge clock);
         hold_off_req = 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (peak_reports_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected report, expected none, actual ballistic_peak=%0d sample_peak=%0d",
                     $time, rsp_data.ballistic_peak, rsp_data.sample_peak);
         end else begin
            want = peak_reports_q.pop_front();
            if (rsp_data.ballistic_peak !== want.ballistic_peak) begin
               mismatches++;
               $display("%0t: ballistic_peak expected %0d actual %0d",
                        $time, want.ballistic_peak, rsp_data.ballistic_peak);
            end
            if (rsp_data.sample_peak !== want.sample_peak) begin
               mismatches++;
               $display("%0t: sample_peak expected %0d actual %0d",
                        $time, want.sample_peak, rsp_data.sample_peak);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      dir_row_type rows[$];
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b0, 1'b1, '0, '0));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b0, 1'b1, '0, '0));
      rows.push_back(make_row(KIND_UNUSED, SAMPLE_MOST_NEG, SAMPLE_MOST_POS, 28'h5555555,
                              28'hAAAAAAA, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_SAMPLES, SAMPLE_MOST_POS, SAMPLE_MOST_POS, SAMPLE_MOST_POS,
                              SAMPLE_MOST_POS, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_SAMPLES, SAMPLE_MOST_NEG, SAMPLE_MOST_NEG, SAMPLE_MOST_NEG,
                              SAMPLE_MOST_NEG, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_SAMPLES, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_SAMPLES, {SAMPLE_W{1'b1}}, 28'd1, SAMPLE_MOST_POS,
                              SAMPLE_MOST_NEG, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b0, 1'b1, '0, '0));
      rows.push_back(make_row(KIND_SAMPLES, 28'd100, -28'sd200, 28'd300, -28'sd400,
                              1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_SAMPLES, 28'd1, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_SAMPLES, 28'h5555555, 28'hAAAAAAA, 28'h2AAAAAA,
                              28'hD555555, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b0, 1'b1, '0, '0));
      rows.push_back(make_row(KIND_SAMPLES, SAMPLE_MOST_NEG, 28'd5, -28'sd5, '0,
                              1'b1, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b1, 1'b1,
                              PEAK_W'(MAG_MAX), MAG_MAX));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_SAMPLES, 28'd3, -28'sd7, 28'd2, 28'd1, 1'b1, 1'b0, '0, '0));
      rows.push_back(make_row(KIND_READ, '0, '0, '0, '0, 1'b1, 1'b1, 29'd7, 28'd7));

      foreach (rows[i]) begin
         if (rows[i].peak_only != m_peak_only) begin
            settle_block();
            write_reg(REG_PEAK_ONLY, COEF_W'(rows[i].peak_only));
            csr_write_en <= 1'b0;
         end
         send_word(rows[i].word, rows[i].typed, rows[i].report);
      end

      run_phase(FAST_ATTACK_RST, SLOW_ATTACK_RST, DECAY_FACTOR_RST, OUTPUT_GAIN_RST, 1'b0,
                0, 0, 250, 1'b0);
      run_phase(COEF_ALL_ONES, COEF_ALL_ONES, COEF_ALL_ONES, COEF_ALL_ONES, 1'b0,
                65, 0, 200, 1'b0);
      run_phase('0, '0, '0, '0, 1'b0, 0, 65, 200, 1'b0);
      run_phase(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                COEF_W'($urandom()), 1'b1, 24, 24, 200, 1'b0);
      run_phase(COEF_W'($urandom()), COEF_W'($urandom()),
                COEF_W'($urandom_range(int'(COEF_ALL_ONES) - 4096, int'(COEF_ALL_ONES))),
                COEF_W'($urandom()), 1'b0, 65, 0, 200, 1'b0);
      run_phase(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                COEF_W'($urandom()), 1'b0, 0, 0, 150, 1'b1);
      run_phase(COEF_W'($urandom()), COEF_W'($urandom()), '0, COEF_ALL_ONES, 1'b1,
                0, 65, 150, 1'b0);
      run_phase(FAST_ATTACK_RST, SLOW_ATTACK_RST, DECAY_FACTOR_RST, OUTPUT_GAIN_RST, 1'b0,
                24, 24, 300, 1'b0);

      settle_block();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
sv/tpbm_pkg.sv
sv/true_peak_ballistic_meter.sv
dv/tb_top.sv
